// ----- rtl/amc_pkg.sv -----
package amc_pkg;

  // Default field widths
  localparam int ID_BITS_DEF  = 20;
  localparam int POS_BITS_DEF = 32;

  // Tolerance register
  localparam int TOL_BITS = 11;
  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(4);

  // Result queue depth, a power of two with room for two pushes behind two waiting entries
  localparam int OUT_DEPTH = 4;

  // Push control toward the result queue: first slot, and a second slot right behind it
  typedef struct packed {
    logic first;
    logic second;
  } amc_push_t;

endpackage

// ----- rtl/amc_if.sv -----
// Alignment record channel
interface amc_rec_if #(
  parameter int ID_BITS  = amc_pkg::ID_BITS_DEF,
  parameter int POS_BITS = amc_pkg::POS_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [ID_BITS-1:0]  target_id;
  logic [ID_BITS-1:0]  query_id;
  logic [POS_BITS-1:0] target_start;
  logic [POS_BITS-1:0] query_start;
  logic [POS_BITS-1:0] match_length;
  logic                reverse_strand;
  logic                last_record;

  modport source (output valid, target_id, query_id, target_start, query_start,
                  match_length, reverse_strand, last_record, input ready);
  modport sink (input valid, target_id, query_id, target_start, query_start,
                match_length, reverse_strand, last_record, output ready);
endinterface

// Merged record channel
interface amc_res_if #(
  parameter int ID_BITS  = amc_pkg::ID_BITS_DEF,
  parameter int POS_BITS = amc_pkg::POS_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [ID_BITS-1:0]  out_target_id;
  logic [ID_BITS-1:0]  out_query_id;
  logic [POS_BITS-1:0] out_target_start;
  logic [POS_BITS-1:0] out_query_start;
  logic [POS_BITS-1:0] out_length;
  logic                out_reverse;
  logic                stream_end;

  modport source (output valid, out_target_id, out_query_id, out_target_start,
                  out_query_start, out_length, out_reverse, stream_end, input ready);
  modport sink (input valid, out_target_id, out_query_id, out_target_start,
                out_query_start, out_length, out_reverse, stream_end, output ready);
endinterface

// Tolerance register write channel
interface amc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [amc_pkg::TOL_BITS-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/adjacent_match_collapse.sv -----
// Channel   Role    Carries
// cfg       sink    overlap_tolerance write data
// records   sink    raw alignment records, last_record closes a stream
// merged    source  merged records, stream_end on the flushed final one
//
// One record is accepted per cycle while the queue has room: it lands in an input register,
// is compared there with the previous record and the pending merged record, and pushes up
// to two results into a four-entry result queue. A record holds in the input register while
// the queue has fewer than two free entries, so a stalled merged channel backs up into
// records.ready after a few transactions. Synchronous reset clears the pending record, the
// queue and the input register, and loads the tolerance with 4.
module adjacent_match_collapse #(
  parameter int ID_BITS  = amc_pkg::ID_BITS_DEF,
  parameter int POS_BITS = amc_pkg::POS_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  amc_cfg_if.sink     cfg,
  amc_rec_if.sink     records,
  amc_res_if.source   merged
);

  localparam int RES_W = 2 * ID_BITS + 3 * POS_BITS + 2;

  // Tolerance register
  logic [amc_pkg::TOL_BITS-1:0] tolerance;

  // Input register
  logic                s_valid;
  logic [ID_BITS-1:0]  s_tid;
  logic [ID_BITS-1:0]  s_qid;
  logic [POS_BITS-1:0] s_ts;
  logic [POS_BITS-1:0] s_qs;
  logic [POS_BITS-1:0] s_len;
  logic                s_rev;
  logic                s_last;

  // Previous raw record
  logic [ID_BITS-1:0]  prev_tid;
  logic                prev_rev;
  logic [POS_BITS-1:0] prev_ts;
  logic [POS_BITS-1:0] prev_qs;

  // Pending merged record
  logic                pending_valid;
  logic [ID_BITS-1:0]  pend_tid;
  logic [ID_BITS-1:0]  pend_qid;
  logic [POS_BITS-1:0] pend_ts;
  logic [POS_BITS-1:0] pend_qs;
  logic [POS_BITS-1:0] pend_len;
  logic                pend_rev;

  logic [ID_BITS-1:0]  pend_tid_next;
  logic [ID_BITS-1:0]  pend_qid_next;
  logic [POS_BITS-1:0] pend_ts_next;
  logic [POS_BITS-1:0] pend_qs_next;
  logic [POS_BITS-1:0] pend_len_next;
  logic                pend_rev_next;

  logic                room;
  logic                adv;
  logic                chain;
  logic                grow_low;
  logic [POS_BITS:0]   span_low;
  logic [POS_BITS:0]   span_high;
  logic [POS_BITS:0]   span;
  logic [POS_BITS-1:0] span_sat;
  amc_pkg::amc_push_t  push;
  logic [RES_W-1:0]    push_data_a;
  logic [RES_W-1:0]    push_data_b;
  logic [RES_W-1:0]    old_res;
  logic                q_valid;
  logic [RES_W-1:0]    q_data;

  function automatic logic near(input logic [POS_BITS-1:0] a,
                                input logic [POS_BITS-1:0] b,
                                input logic [amc_pkg::TOL_BITS-1:0] tol);
    logic [POS_BITS-1:0] diff;
    diff = (a >= b) ? (a - b) : (b - a);
    return diff < POS_BITS'(tol);
  endfunction

  // Accept configuration writes at any time
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= amc_pkg::TOL_RESET;
    end else if (cfg.valid) begin
      tolerance <= cfg.data;
    end
  end

  // Advance the input register when the queue can take two results
  assign adv           = s_valid && room;
  assign records.ready = !s_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (records.ready) begin
      s_valid <= records.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (records.valid && records.ready) begin
      s_tid  <= records.target_id;
      s_qid  <= records.query_id;
      s_ts   <= records.target_start;
      s_qs   <= records.query_start;
      s_len  <= records.match_length;
      s_rev  <= records.reverse_strand;
      s_last <= records.last_record;
    end
  end

  // Decide whether the record chains and work out the widened span
  always_comb begin
    chain = pending_valid && (s_tid == prev_tid) && (s_rev == prev_rev) &&
            near(s_ts, prev_ts, tolerance) && near(s_qs, prev_qs, tolerance);
    grow_low  = s_qs < pend_qs;
    span_low  = {1'b0, pend_qs} + {1'b0, pend_len} - {1'b0, s_qs};
    span_high = {1'b0, s_qs} + {1'b0, s_len} - {1'b0, pend_qs};
    span      = grow_low ? span_low : span_high;
    span_sat  = span[POS_BITS] ? '1 : span[POS_BITS-1:0];
  end

  // Widen the pending record or open a new one
  always_comb begin
    if (chain) begin
      pend_tid_next = pend_tid;
      pend_qid_next = pend_qid;
      pend_ts_next  = pend_ts;
      pend_qs_next  = grow_low ? s_qs : pend_qs;
      pend_len_next = span_sat;
      pend_rev_next = pend_rev;
    end else begin
      pend_tid_next = s_tid;
      pend_qid_next = s_qid;
      pend_ts_next  = s_ts;
      pend_qs_next  = s_qs;
      pend_len_next = s_len;
      pend_rev_next = s_rev;
    end
  end

  // Emit the old pending record on a break, and the updated one on the last record
  always_comb begin
    old_res = {pend_tid, pend_qid, pend_ts, pend_qs, pend_len, pend_rev, 1'b0};
    push_data_b = {pend_tid_next, pend_qid_next, pend_ts_next, pend_qs_next,
                   pend_len_next, pend_rev_next, 1'b1};
    if (adv && !chain && pending_valid) begin
      push.first  = 1'b1;
      push.second = s_last;
      push_data_a = old_res;
    end else begin
      push.first  = adv && s_last;
      push.second = 1'b0;
      push_data_a = push_data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
    end else if (adv) begin
      pending_valid <= !s_last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prev_tid <= s_tid;
      prev_rev <= s_rev;
      prev_ts  <= s_ts;
      prev_qs  <= s_qs;
      pend_tid <= pend_tid_next;
      pend_qid <= pend_qid_next;
      pend_ts  <= pend_ts_next;
      pend_qs  <= pend_qs_next;
      pend_len <= pend_len_next;
      pend_rev <= pend_rev_next;
    end
  end

  amc_out_fifo #(
    .WIDTH (RES_W),
    .DEPTH (amc_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_data_a (push_data_a),
    .push_data_b (push_data_b),
    .room        (room),
    .out_valid   (q_valid),
    .out_data    (q_data),
    .pop         (merged.ready)
  );

  // Unpack the queue head onto the merged channel
  assign merged.valid = q_valid;
  assign {merged.out_target_id, merged.out_query_id, merged.out_target_start,
          merged.out_query_start, merged.out_length, merged.out_reverse,
          merged.stream_end} = q_data;

endmodule

// ----- rtl/amc_out_fifo.sv -----
module amc_out_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = amc_pkg::OUT_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  amc_pkg::amc_push_t push,
  input  logic [WIDTH-1:0]   push_data_a,
  input  logic [WIDTH-1:0]   push_data_b,
  output logic               room,
  output logic               out_valid,
  output logic [WIDTH-1:0]   out_data,
  input  logic               pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic             do_pop;

  assign do_pop    = pop && (count != '0);
  assign out_valid = (count != '0);
  assign out_data  = mem[rptr];
  // Two free entries are needed, since one transaction may leave two results
  assign room      = (count <= CW'(DEPTH - 2));

  always_comb begin
    count_next = count + CW'(push.first) + CW'(push.second) - CW'(do_pop);
  end

  // Store pushed entries in order
  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wptr] <= push_data_a;
    end
    if (push.second) begin
      mem[PW'(wptr + 1'b1)] <= push_data_b;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PW'(push.first) + PW'(push.second);
      rptr  <= rptr + PW'(do_pop);
      count <= count_next;
    end
  end

endmodule

// ----- rtl/amc_checker.sv -----
module amc_checker #(
  parameter int ID_BITS  = amc_pkg::ID_BITS_DEF,
  parameter int POS_BITS = amc_pkg::POS_BITS_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                rec_ready,
  input logic                res_valid,
  input logic                res_ready,
  input logic [ID_BITS-1:0]  res_target_id,
  input logic [POS_BITS-1:0] res_query_start,
  input logic [POS_BITS-1:0] res_length,
  input logic                res_end
);

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("merged transaction dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_target_id) && $stable(res_query_start) &&
                                $stable(res_length) && $stable(res_end))
    else $error("merged payload changed while stalled");

  // Come out of reset empty and ready for records
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("merged transaction offered right after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> rec_ready)
    else $error("records not accepted right after reset");

endmodule

bind adjacent_match_collapse amc_checker #(
  .ID_BITS  (ID_BITS),
  .POS_BITS (POS_BITS)
) u_amc_checker (
  .clk             (clk),
  .rst             (rst),
  .rec_ready       (records.ready),
  .res_valid       (merged.valid),
  .res_ready       (merged.ready),
  .res_target_id   (merged.out_target_id),
  .res_query_start (merged.out_query_start),
  .res_length      (merged.out_length),
  .res_end         (merged.stream_end)
);
